// ===== src/mi3_pkg.sv =====
// types, constants and the cofactor index table for the 3x3 matrix inverse
// used by every module of the block, no dependencies
package mi3_pkg;

   // element format of the incoming matrix
   localparam int IN_WIDTH = 16;
   localparam int IN_FRAC  = 8;

   // result format, signed Q16.16
   localparam int OUT_W    = 32;
   localparam int OUT_FRAC = 16;

   // derived widths
   localparam int PROD_W = 2 * IN_WIDTH;          // element times element
   localparam int ADJ_W  = 2 * IN_WIDTH + 1;      // adjugate entry
   localparam int TP_W   = ADJ_W + IN_WIDTH;      // adjugate times element
   localparam int DET_W  = 3 * IN_WIDTH + 3;      // determinant
   localparam int QB     = OUT_W + 2;             // quotient bits per lane
   localparam int REM_W  = DET_W + QB;            // divider remainder
   localparam int NUM_SH = IN_FRAC + OUT_FRAC;    // numerator scaling

   // pipeline depths
   localparam int FRONT_DEPTH = 4;
   localparam int LANE_DEPTH  = QB + 1;
   localparam int TOTAL_DEPTH = FRONT_DEPTH + LANE_DEPTH;

   localparam int NUM_ELEM = 9;

   typedef logic signed [IN_WIDTH-1:0] elem_type;
   typedef logic signed [ADJ_W-1:0]    adj_type;
   typedef logic signed [DET_W-1:0]    det_type;
   typedef logic [QB-1:0]              quo_type;
   typedef logic [3:0]                 idx_type;

   typedef elem_type elem_arr_type [NUM_ELEM];
   typedef adj_type  adj_arr_type  [NUM_ELEM];
   typedef quo_type  quo_arr_type  [NUM_ELEM];

   typedef struct packed {
      elem_type m_r0c0;
      elem_type m_r0c1;
      elem_type m_r0c2;
      elem_type m_r1c0;
      elem_type m_r1c1;
      elem_type m_r1c2;
      elem_type m_r2c0;
      elem_type m_r2c1;
      elem_type m_r2c2;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] inv_r0c0;
      logic signed [OUT_W-1:0] inv_r0c1;
      logic signed [OUT_W-1:0] inv_r0c2;
      logic signed [OUT_W-1:0] inv_r1c0;
      logic signed [OUT_W-1:0] inv_r1c1;
      logic signed [OUT_W-1:0] inv_r1c2;
      logic signed [OUT_W-1:0] inv_r2c0;
      logic signed [OUT_W-1:0] inv_r2c1;
      logic signed [OUT_W-1:0] inv_r2c2;
      logic                    singular;
   } rsp_type;

   // adjugate entry k = m[p]*m[q] - m[r]*m[s]
   typedef idx_type adj_idx_row_type [4];
   localparam adj_idx_row_type ADJ_IDX [NUM_ELEM] = '{
      '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
      '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
      '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
   };

endpackage

// ===== src/mi3_cofactor.sv =====
// four-stage front end: adjugate by cofactors and determinant by first-row expansion
// depends on mi3_pkg
module mi3_cofactor import mi3_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  req_type     req,
   output adj_arr_type adj,
   output det_type     det
);

   elem_arr_type m;
   logic signed [PROD_W-1:0] pp_ff [NUM_ELEM];
   logic signed [PROD_W-1:0] pq_ff [NUM_ELEM];
   elem_type    row_a_ff [3];
   elem_type    row_b_ff [3];
   adj_arr_type adj_b_ff;
   adj_arr_type adj_c_ff;
   adj_arr_type adj_d_ff;
   logic signed [TP_W-1:0] tp_ff [3];
   det_type     det_ff;

   // element view of the transaction
   assign m[0] = req.m_r0c0;
   assign m[1] = req.m_r0c1;
   assign m[2] = req.m_r0c2;
   assign m[3] = req.m_r1c0;
   assign m[4] = req.m_r1c1;
   assign m[5] = req.m_r1c2;
   assign m[6] = req.m_r2c0;
   assign m[7] = req.m_r2c1;
   assign m[8] = req.m_r2c2;

   // cofactor products, then differences, then first-row terms, then sum
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NUM_ELEM; k++) begin
            pp_ff[k] <= m[ADJ_IDX[k][0]] * m[ADJ_IDX[k][1]];
            pq_ff[k] <= m[ADJ_IDX[k][2]] * m[ADJ_IDX[k][3]];
            adj_b_ff[k] <= ADJ_W'(pp_ff[k]) - ADJ_W'(pq_ff[k]);
         end
         for (int i = 0; i < 3; i++) begin
            row_a_ff[i] <= m[i];
            row_b_ff[i] <= row_a_ff[i];
            tp_ff[i] <= adj_b_ff[3 * i] * row_b_ff[i];
         end
         adj_c_ff <= adj_b_ff;
         adj_d_ff <= adj_c_ff;
         det_ff   <= DET_W'(tp_ff[0]) + DET_W'(tp_ff[1]) + DET_W'(tp_ff[2]);
      end
   end

   assign adj = adj_d_ff;
   assign det = det_ff;

endmodule

// ===== src/mi3_div_lane.sv =====
// one divider lane: sign/magnitude split, then one restoring step per stage
// depends on mi3_pkg
module mi3_div_lane import mi3_pkg::*; (
   input  logic    clock,
   input  logic    en,
   input  adj_type adj,
   input  det_type det,
   output quo_type quo,
   output logic    neg
);

   logic [REM_W-1:0] rem_ff [QB];
   logic [DET_W-1:0] den_ff [QB];
   quo_type          q_ff   [1:QB];
   logic             neg_ff [QB+1];
   logic [ADJ_W-1:0] adj_mag;
   logic [DET_W-1:0] det_mag;

   // magnitudes; the most negative value maps onto its own unsigned bits
   assign adj_mag = adj[ADJ_W-1] ? ADJ_W'(-adj) : ADJ_W'(adj);
   assign det_mag = det[DET_W-1] ? DET_W'(-det) : DET_W'(det);

   // entry stage: scaled numerator and divisor
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= REM_W'(adj_mag) << NUM_SH;
         den_ff[0] <= det_mag;
         neg_ff[0] <= adj[ADJ_W-1] ^ det[DET_W-1];
      end
   end

   // one quotient bit per stage, top bit catches any overflow
   for (genvar s = 1; s <= QB; s++) begin : g_step
      logic [REM_W-1:0] dsh;
      logic             ge;
      assign dsh = REM_W'(den_ff[s-1]) << (QB - s);
      assign ge  = rem_ff[s-1] >= dsh;

      always_ff @(posedge clock) begin
         if (en) begin
            neg_ff[s] <= neg_ff[s-1];
         end
      end

      if (s == 1) begin : g_first
         always_ff @(posedge clock) begin
            if (en) begin
               q_ff[s] <= QB'(ge);
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (en) begin
               q_ff[s] <= {q_ff[s-1][QB-2:0], ge};
            end
         end
      end

      if (s < QB) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s] <= ge ? rem_ff[s-1] - dsh : rem_ff[s-1];
               den_ff[s] <= den_ff[s-1];
            end
         end
      end
   end

   assign quo = q_ff[QB];
   assign neg = neg_ff[QB];

endmodule

// ===== src/mi3_merge.sv =====
// merging stage: signs, saturates and zeroes the nine lane quotients
// depends on mi3_pkg
module mi3_merge import mi3_pkg::*; (
   input  quo_arr_type quo,
   input  logic        neg [NUM_ELEM],
   input  logic        sing,
   output rsp_type     rsp
);

   logic signed [OUT_W-1:0] val [NUM_ELEM];

   // truncated quotient to saturated two's complement
   function automatic logic [OUT_W-1:0] fix_lane(input quo_type q, input logic n);
      logic hi;
      logic [OUT_W-1:0] r;
      hi = |q[QB-1:OUT_W];
      if (n) begin
         if (hi || (q[OUT_W-1] && (|q[OUT_W-2:0]))) begin
            r = {1'b1, {(OUT_W-1){1'b0}}};
         end else begin
            r = OUT_W'(0) - q[OUT_W-1:0];
         end
      end else begin
         if (hi || q[OUT_W-1]) begin
            r = {1'b0, {(OUT_W-1){1'b1}}};
         end else begin
            r = q[OUT_W-1:0];
         end
      end
      return r;
   endfunction

   // per-lane result, cleared when the matrix is singular
   always_comb begin
      for (int k = 0; k < NUM_ELEM; k++) begin
         val[k] = sing ? '0 : fix_lane(quo[k], neg[k]);
      end
   end

   assign rsp.inv_r0c0 = val[0];
   assign rsp.inv_r0c1 = val[1];
   assign rsp.inv_r0c2 = val[2];
   assign rsp.inv_r1c0 = val[3];
   assign rsp.inv_r1c1 = val[4];
   assign rsp.inv_r1c2 = val[5];
   assign rsp.inv_r2c0 = val[6];
   assign rsp.inv_r2c1 = val[7];
   assign rsp.inv_r2c2 = val[8];
   assign rsp.singular = sing;

endmodule

// ===== src/matrix_inverse_3x3.sv =====
// 3x3 matrix inverse: adjugate over determinant, Q8.8 in, saturated Q16.16 out
// the accepting edge loads the first of 40 register stages: 4 front, 35 in each of
// nine divider lanes and one output; each lane retires one quotient bit per stage
// throughput: one transaction per cycle while req_stall is low
// reset clears all valid flags, the skid flag among them; payload registers are not reset
module matrix_inverse_3x3 import mi3_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic        en;
   logic        vld_ff  [TOTAL_DEPTH];
   logic        sing_ff [LANE_DEPTH];
   adj_arr_type adj;
   det_type     det;
   quo_arr_type quo;
   logic        neg [NUM_ELEM];
   rsp_type     merged;
   rsp_type     rsp_ff;
   logic        rsp_v_ff;
   rsp_type     skid_ff;
   logic        skid_v_ff;

   // the pipeline moves whenever the skid register is empty
   assign en        = !skid_v_ff;
   assign req_stall = skid_v_ff;

   mi3_cofactor u_cofactor (
      .clock (clock),
      .en    (en),
      .req   (req_data),
      .adj   (adj),
      .det   (det)
   );

   for (genvar k = 0; k < NUM_ELEM; k++) begin : g_lane
      mi3_div_lane u_lane (
         .clock (clock),
         .en    (en),
         .adj   (adj[k]),
         .det   (det),
         .quo   (quo[k]),
         .neg   (neg[k])
      );
   end

   mi3_merge u_merge (
      .quo  (quo),
      .neg  (neg),
      .sing (sing_ff[LANE_DEPTH-1]),
      .rsp  (merged)
   );

   // valid tracking through the whole pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TOTAL_DEPTH; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < TOTAL_DEPTH; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // singular flag runs alongside the divider lanes
   always_ff @(posedge clock) begin
      if (en) begin
         sing_ff[0] <= (det == '0);
         for (int i = 1; i < LANE_DEPTH; i++) sing_ff[i] <= sing_ff[i-1];
      end
   end

   // output register with skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!rsp_v_ff || !rsp_stall) begin
         if (skid_v_ff) begin
            rsp_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            rsp_v_ff <= vld_ff[TOTAL_DEPTH-1];
         end
      end else if (vld_ff[TOTAL_DEPTH-1] && en) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_v_ff || !rsp_stall) begin
         rsp_ff <= skid_v_ff ? skid_ff : merged;
      end else if (!skid_v_ff) begin
         skid_ff <= merged;
      end
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== tb/matrix_inverse_3x3_test.sv =====
// testbench for matrix_inverse_3x3: directed and random 3x3 matrices, checked against
// an exact adjugate / determinant predictor held in a small scoreboard class
// depends on mi3_pkg and the matrix_inverse_3x3 rtl
`timescale 1ns / 1ps

module matrix_inverse_3x3_test;
   import mi3_pkg::*;

   // expected inverses in order of acceptance, compared field by field
   class inverse_scoreboard;
      rsp_type pending_inverses[$];
      int unsigned mismatches;
      int unsigned checked;
      int unsigned singular_seen;
      int unsigned saturated_seen;

      function automatic longint divide_q16(longint adj_val, longint det_val);
         longint quo;
         quo = (adj_val <<< (IN_FRAC + OUT_FRAC)) / det_val;
         if (quo > 64'sd2147483647) begin
            saturated_seen++;
            return 64'sd2147483647;
         end
         if (quo < -64'sd2147483648) begin
            saturated_seen++;
            return -64'sd2147483648;
         end
         return quo;
      endfunction

      // exact inverse: cofactors, first-row determinant, truncating divide
      function automatic rsp_type predict_inverse(req_type m);
         longint e[9];
         longint adj[9];
         longint det;
         rsp_type r;
         e = '{m.m_r0c0, m.m_r0c1, m.m_r0c2, m.m_r1c0, m.m_r1c1, m.m_r1c2,
               m.m_r2c0, m.m_r2c1, m.m_r2c2};
         adj[0] = e[4] * e[8] - e[5] * e[7];
         adj[1] = e[2] * e[7] - e[1] * e[8];
         adj[2] = e[1] * e[5] - e[2] * e[4];
         adj[3] = e[5] * e[6] - e[3] * e[8];
         adj[4] = e[0] * e[8] - e[2] * e[6];
         adj[5] = e[2] * e[3] - e[0] * e[5];
         adj[6] = e[3] * e[7] - e[4] * e[6];
         adj[7] = e[1] * e[6] - e[0] * e[7];
         adj[8] = e[0] * e[4] - e[1] * e[3];
         det = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
         r = '0;
         if (det == 0) begin
            r.singular = 1'b1;
            singular_seen++;
            return r;
         end
         r.inv_r0c0 = divide_q16(adj[0], det);
         r.inv_r0c1 = divide_q16(adj[1], det);
         r.inv_r0c2 = divide_q16(adj[2], det);
         r.inv_r1c0 = divide_q16(adj[3], det);
         r.inv_r1c1 = divide_q16(adj[4], det);
         r.inv_r1c2 = divide_q16(adj[5], det);
         r.inv_r2c0 = divide_q16(adj[6], det);
         r.inv_r2c1 = divide_q16(adj[7], det);
         r.inv_r2c2 = divide_q16(adj[8], det);
         return r;
      endfunction

      function void note_matrix(req_type m);
         pending_inverses.push_back(predict_inverse(m));
      endfunction

      function void check_inverse(rsp_type got);
         rsp_type want;
         logic [OUT_W-1:0] w_ent[9];
         logic [OUT_W-1:0] g_ent[9];
         if (pending_inverses.size() == 0) begin
            $display("%0t: unexpected transaction on rsp: %h", $time, got);
            mismatches++;
            return;
         end
         want = pending_inverses.pop_front();
         checked++;
         w_ent = '{want.inv_r0c0, want.inv_r0c1, want.inv_r0c2, want.inv_r1c0,
                   want.inv_r1c1, want.inv_r1c2, want.inv_r2c0, want.inv_r2c1,
                   want.inv_r2c2};
         g_ent = '{got.inv_r0c0, got.inv_r0c1, got.inv_r0c2, got.inv_r1c0,
                   got.inv_r1c1, got.inv_r1c2, got.inv_r2c0, got.inv_r2c1,
                   got.inv_r2c2};
         for (int k = 0; k < 9; k++) begin
            if (w_ent[k] !== g_ent[k]) begin
               $display("%0t: inv r%0dc%0d expected %h actual %h", $time, k / 3, k % 3,
                        w_ent[k], g_ent[k]);
               mismatches++;
            end
         end
         if (want.singular !== got.singular) begin
            $display("%0t: singular expected %b actual %b", $time, want.singular,
                     got.singular);
            mismatches++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   inverse_scoreboard sb;
   int unsigned stall_left;
   int unsigned sent_count;

   matrix_inverse_3x3 u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      #4ms;
      $display("timeout with %0d results outstanding", sb.pending_inverses.size());
      $display("CHECK FAILED");
      $finish;
   end

   // random gap length, mostly short, sometimes long
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 55) return 0;
      if (roll < 93) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // receiver stall, changed at the falling edge, with stall-free stretches
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (((sent_count / 300) % 2) == 1 || $urandom_range(99) < 70) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_left <= pick_gap();
         rsp_stall  <= 1'b1;
      end
   end

   // accepted result transactions
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_inverse(rsp_data);
   end

   // one request transaction, then an optional idle gap
   task automatic send_matrix(input req_type m, input bit allow_gap);
      int unsigned gap;
      req_data  <= m;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_matrix(m);
      sent_count++;
      @(negedge clock);
      gap = allow_gap ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   function automatic req_type diag_matrix(elem_type a, elem_type b, elem_type c);
      req_type m;
      m = '0;
      m.m_r0c0 = a;
      m.m_r1c1 = b;
      m.m_r2c2 = c;
      return m;
   endfunction

   // random matrix in one of several styles
   function automatic req_type random_matrix();
      req_type m;
      int unsigned style;
      m = req_type'({$urandom, $urandom, $urandom, $urandom, 16'($urandom)});
      style = $urandom_range(9);
      case (style)
         0, 1: begin
            // small elements, frequent singular and saturating cases
            m.m_r0c0 = 16'($signed($urandom_range(8)) - 4);
            m.m_r0c1 = 16'($signed($urandom_range(8)) - 4);
            m.m_r0c2 = 16'($signed($urandom_range(8)) - 4);
            m.m_r1c0 = 16'($signed($urandom_range(8)) - 4);
            m.m_r1c1 = 16'($signed($urandom_range(8)) - 4);
            m.m_r1c2 = 16'($signed($urandom_range(8)) - 4);
            m.m_r2c0 = 16'($signed($urandom_range(8)) - 4);
            m.m_r2c1 = 16'($signed($urandom_range(8)) - 4);
            m.m_r2c2 = 16'($signed($urandom_range(8)) - 4);
         end
         2: begin
            // duplicated row, always singular
            m.m_r2c0 = m.m_r0c0;
            m.m_r2c1 = m.m_r0c1;
            m.m_r2c2 = m.m_r0c2;
         end
         3: begin
            // perturbed Q8.8 identity diagonal; r0c1, r1c2 and r2c0 small, other off-diagonals random
            m.m_r0c0 = 16'(256 + $signed($urandom_range(64)) - 32);
            m.m_r1c1 = 16'(256 + $signed($urandom_range(64)) - 32);
            m.m_r2c2 = 16'(256 + $signed($urandom_range(64)) - 32);
            m.m_r0c1 = 16'($signed($urandom_range(64)) - 32);
            m.m_r1c2 = 16'($signed($urandom_range(64)) - 32);
            m.m_r2c0 = 16'($signed($urandom_range(64)) - 32);
         end
         4: begin
            // upper triangular with tiny diagonal, large off-diagonal
            m.m_r1c0 = '0;
            m.m_r2c0 = '0;
            m.m_r2c1 = '0;
            m.m_r0c0 = 16'($signed($urandom_range(6)) - 3);
            m.m_r1c1 = 16'($signed($urandom_range(6)) - 3);
            m.m_r2c2 = 16'($signed($urandom_range(6)) - 3);
         end
         default: ;
      endcase
      return m;
   endfunction

   initial begin
      req_type m;
      sb = new();
      sent_count = 0;
      stall_left = 0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: identity, zero, extremes, saturation and zero quotients
      send_matrix(diag_matrix(16'sd256, 16'sd256, 16'sd256), 1'b0);
      send_matrix('0, 1'b0);
      send_matrix({9{16'h8000}}, 1'b0);
      send_matrix({9{16'h7fff}}, 1'b0);
      send_matrix(diag_matrix(-16'sd32768, -16'sd32768, -16'sd32768), 1'b0);
      send_matrix(diag_matrix(16'sd32767, 16'sd32767, 16'sd32767), 1'b0);
      send_matrix(diag_matrix(16'sd32767, -16'sd32768, 16'sd32767), 1'b0);
      send_matrix(diag_matrix(16'sd1, 16'sd1, 16'sd1), 1'b0);
      send_matrix(diag_matrix(-16'sd1, 16'sd1, 16'sd1), 1'b0);
      m = diag_matrix(16'sd1, 16'sd1, 16'sd1);
      m.m_r0c1 = 16'sd32767;
      send_matrix(m, 1'b0);
      m.m_r0c1 = -16'sd32768;
      send_matrix(m, 1'b0);
      m = diag_matrix(16'sd32767, 16'sd32767, 16'sd32767);
      m.m_r0c1 = 16'sd1;
      send_matrix(m, 1'b0);
      m.m_r0c1 = -16'sd1;
      send_matrix(m, 1'b0);
      m = '0;
      m.m_r0c2 = 16'sd256;
      m.m_r1c1 = -16'sd256;
      m.m_r2c0 = 16'sd256;
      send_matrix(m, 1'b0);
      send_matrix({16'sd256, 16'sd512, 16'sd768, 16'sd1024, 16'sd1280, 16'sd1536,
                   16'sd1792, 16'sd2048, 16'sd2304}, 1'b0);
      send_matrix({9{16'hffff}}, 1'b0);
      send_matrix({16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
                   16'h5555, 16'haaaa, 16'h0001}, 1'b0);
      send_matrix({16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555,
                   16'haaaa, 16'h5555, 16'hfffe}, 1'b1);

      // hold off until the pipeline drains once
      req_valid <= 1'b0;
      while (sb.pending_inverses.size() != 0) @(negedge clock);

      for (int i = 0; i < 1850; i++) begin
         send_matrix(random_matrix(), ((i / 250) % 3) != 1);
      end
      req_valid <= 1'b0;

      fork
         while (sb.pending_inverses.size() != 0) @(posedge clock);
         begin
            repeat (200000) @(posedge clock);
         end
      join_any
      disable fork;
      repeat (60) @(posedge clock);

      $display("sent %0d matrices, checked %0d inverses, %0d singular, %0d saturated entries",
               sent_count, sb.checked, sb.singular_seen, sb.saturated_seen);
      if (sb.mismatches == 0 && sb.pending_inverses.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.mismatches,
                  sb.pending_inverses.size());
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
